### rtl/gsa_pkg.sv
// gsa_pkg: shared types and constants for the generational slot allocator.
// Fixed field widths, request kinds and status codes. No dependencies.
package gsa_pkg;

	localparam int KIND_W   = 3;
	localparam int IDX_W    = 8;
	localparam int STAMP_W  = 16;
	localparam int CNT_W    = 9;
	localparam int STATUS_W = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_CREATE     = 3'd0,
		KIND_DESTROY    = 3'd1,
		KIND_INVALIDATE = 3'd2,
		KIND_CHECK      = 3'd3,
		KIND_CLEAR      = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_STALE    = 2'd2,
		ST_NOT_LIVE = 2'd3
	} status_t;

endpackage

### rtl/gsa_slot_ram.sv
// gsa_slot_ram: single-port-write, single-port-read slot word memory.
// Read data registered. No dependencies.
module gsa_slot_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 18
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/generational_slot_allocator_core.sv
// generational_slot_allocator_core: handle allocator with per-slot stamps and
// an embedded free list. Depends on gsa_pkg and gsa_slot_ram.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   request | in_valid, in_stall, kind, slot_index,     | in
//           | handle_stamp                              |
//   result  | out_valid, out_stall, status, out_index,  | out
//           | out_stamp, live_count, slots_touched      |
//
// Each request: slot memory read at accept, then read-modify-write and
// result register load in S_EXEC. One request in flight.
// A new request is taken while a result waits; it holds in S_EXEC
// until the result register frees up.
// Reset leaves the slot memory as is: no clearing pass, no wait after reset.
module generational_slot_allocator_core #(
	parameter int SLOTS      = 256,
	parameter int STAMP_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [gsa_pkg::KIND_W-1:0]     kind,
	input  logic [gsa_pkg::IDX_W-1:0]      slot_index,
	input  logic [gsa_pkg::STAMP_W-1:0]    handle_stamp,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [gsa_pkg::STATUS_W-1:0]   status,
	output logic [gsa_pkg::IDX_W-1:0]      out_index,
	output logic [gsa_pkg::STAMP_W-1:0]    out_stamp,
	output logic [gsa_pkg::CNT_W-1:0]      live_count,
	output logic [gsa_pkg::CNT_W-1:0]      slots_touched
);

	import gsa_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int LW = IW + 1;
	localparam int VW = (STAMP_BITS > LW) ? STAMP_BITS : LW;
	localparam int WW = VW + 1;
	localparam logic [LW-1:0] LIST_END = {1'b1, {IW{1'b0}}};

	typedef enum logic {S_IDLE, S_EXEC} state_t;

	state_t                state_q;
	logic                  out_valid_q;
	status_t               status_q;
	logic [IDX_W-1:0]      out_index_q;
	logic [STAMP_W-1:0]    out_stamp_q;
	logic [LW-1:0]         free_head_q;
	logic [CW-1:0]         touched_q;
	logic [CW-1:0]         live_q;
	logic [STAMP_BITS-1:0] stamp_q;

	logic [KIND_W-1:0]     kind_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [STAMP_W-1:0]    hstamp_s1;

	logic                  in_accept;
	logic                  exec_done;
	logic [IW-1:0]         rd_addr;
	logic [WW-1:0]         rd_data;
	logic                  wr_en;
	logic [IW-1:0]         wr_addr;
	logic [WW-1:0]         wr_data;

	logic                  rd_free;
	logic [STAMP_BITS-1:0] rd_stamp;
	logic [LW-1:0]         rd_link;
	logic                  in_range;
	logic                  handle_ok;
	logic [STAMP_BITS-1:0] stamp_inc;
	logic [STAMP_BITS-1:0] slot_inc;

	status_t               status_d;
	logic [IDX_W-1:0]      out_index_d;
	logic [STAMP_W-1:0]    out_stamp_d;
	logic [LW-1:0]         free_head_d;
	logic [CW-1:0]         touched_d;
	logic [CW-1:0]         live_d;
	logic [STAMP_BITS-1:0] stamp_d;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign exec_done = (state_q == S_EXEC) && !(out_valid_q && out_stall);

	assign rd_addr = (kind == KIND_CREATE) ? free_head_q[IW-1:0] : IW'(slot_index);

	gsa_slot_ram #(
		.DEPTH (SLOTS),
		.WIDTH (WW)
	) u_slot_ram (
		.clk     (clk),
		.rd_en   (in_accept),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	assign rd_free   = rd_data[VW];
	assign rd_stamp  = rd_data[STAMP_BITS-1:0];
	assign rd_link   = rd_data[LW-1:0];
	assign in_range  = 32'(idx_s1) < 32'(touched_q);
	assign handle_ok = in_range && !rd_free && (32'(rd_stamp) == 32'(hstamp_s1));
	assign stamp_inc = stamp_q + 1'b1;
	assign slot_inc  = rd_stamp + 1'b1;

	always_comb begin
		status_d    = ST_OK;
		out_index_d = idx_s1;
		out_stamp_d = '0;
		free_head_d = free_head_q;
		touched_d   = touched_q;
		live_d      = live_q;
		stamp_d     = stamp_q;
		wr_en       = 1'b0;
		wr_addr     = IW'(idx_s1);
		wr_data     = '0;
		case (kind_s1)
			KIND_CREATE: begin
				if (!free_head_q[IW]) begin
					wr_en       = 1'b1;
					wr_addr     = free_head_q[IW-1:0];
					wr_data     = {1'b0, VW'(stamp_inc)};
					free_head_d = rd_link;
					stamp_d     = stamp_inc;
					live_d      = live_q + 1'b1;
					out_index_d = IDX_W'(free_head_q[IW-1:0]);
					out_stamp_d = STAMP_W'(stamp_inc);
				end else if (touched_q != CW'(SLOTS)) begin
					wr_en       = 1'b1;
					wr_addr     = IW'(touched_q);
					wr_data     = {1'b0, VW'(stamp_inc)};
					stamp_d     = stamp_inc;
					touched_d   = touched_q + 1'b1;
					live_d      = live_q + 1'b1;
					out_index_d = IDX_W'(touched_q);
					out_stamp_d = STAMP_W'(stamp_inc);
				end else begin
					status_d    = ST_FULL;
					out_index_d = '0;
				end
			end
			KIND_DESTROY: begin
				if (handle_ok) begin
					wr_en       = 1'b1;
					wr_data     = {1'b1, VW'(free_head_q)};
					free_head_d = LW'(idx_s1);
					live_d      = live_q - 1'b1;
					out_stamp_d = STAMP_W'(rd_stamp);
				end else begin
					status_d = ST_STALE;
				end
			end
			KIND_INVALIDATE: begin
				if (in_range && !rd_free) begin
					wr_en       = 1'b1;
					wr_data     = {1'b0, VW'(slot_inc)};
					out_stamp_d = STAMP_W'(slot_inc);
				end else begin
					status_d = ST_NOT_LIVE;
				end
			end
			KIND_CHECK: begin
				if (handle_ok) begin
					out_stamp_d = STAMP_W'(rd_stamp);
				end else begin
					status_d = ST_STALE;
				end
			end
			KIND_CLEAR: begin
				touched_d   = '0;
				live_d      = '0;
				free_head_d = LIST_END;
			end
			default: begin
				status_d = ST_STALE;
			end
		endcase
		if (!exec_done) begin
			wr_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			free_head_q <= LIST_END;
			touched_q   <= '0;
			live_q      <= '0;
			stamp_q     <= '0;
		end else begin
			if (exec_done) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_done) begin
						state_q     <= S_IDLE;
						free_head_q <= free_head_d;
						touched_q   <= touched_d;
						live_q      <= live_d;
						stamp_q     <= stamp_d;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1   <= kind;
			idx_s1    <= slot_index;
			hstamp_s1 <= handle_stamp;
		end
		if (exec_done) begin
			status_q    <= status_d;
			out_index_q <= out_index_d;
			out_stamp_q <= out_stamp_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign out_index     = out_index_q;
	assign out_stamp     = out_stamp_q;
	assign live_count    = CNT_W'(live_q);
	assign slots_touched = CNT_W'(touched_q);

endmodule
